### src/dse_pkg.sv
// Drive enable sequencer package: state codes, statusword and controlword
// constants, and the structs passed between the step logic and the top level.
// No dependencies.
package dse_pkg;

	// sequencer states; STOPPING and DISABLE both report as code 7
	typedef enum logic [3:0] {
		ST_STOP        = 4'd0,
		ST_ENABLE      = 4'd1,
		ST_CTRL1       = 4'd2,
		ST_CTRL2       = 4'd3,
		ST_ENGAGING    = 4'd4,
		ST_MOTION      = 4'd5,
		ST_DISENGAGING = 4'd6,
		ST_STOPPING    = 4'd7,
		ST_DISABLE     = 4'd8
	} seq_state_t;

	localparam logic [2:0] SHOWN_STOPPING = 3'd7;

	// motion request codes
	localparam logic [1:0] REQ_ENABLE  = 2'd1;
	localparam logic [1:0] REQ_DISABLE = 2'd2;

	// operating mode class that adds the interpolation enable bit
	localparam logic [1:0] MODE_POSITION = 2'd1;

	localparam logic [15:0] WATCHDOG_TICKS = 16'd1000;
	localparam logic [15:0] WDOG_MAX       = 16'hffff;

	// statusword masks and patterns
	localparam logic [15:0] MASK_STATE_A          = 16'h004f;
	localparam logic [15:0] MASK_STATE_B          = 16'h006f;
	localparam logic [15:0] SW_FAULT              = 16'h0008;
	localparam logic [15:0] SW_FAULT_REACTION     = 16'h000f;
	localparam logic [15:0] SW_SWITCH_ON_DISABLED = 16'h0040;
	localparam logic [15:0] SW_READY              = 16'h0021;
	localparam logic [15:0] SW_SWITCHED_ON        = 16'h0023;
	localparam logic [15:0] SW_OP_ENABLED         = 16'h0027;
	localparam logic [15:0] SW_QUICK_STOP_ACTIVE  = 16'h0007;

	// controlword commands
	localparam logic [15:0] CW_NONE        = 16'h0000;
	localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
	localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
	localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
	localparam logic [15:0] CW_ENABLE_OP   = 16'h000f;
	localparam logic [15:0] CW_QUICK_STOP  = 16'h0002;
	localparam logic [15:0] CW_IP_ENABLE   = 16'h0010;

	typedef struct packed {
		logic        motor_on;
		logic [15:0] drive_status;
		logic [1:0]  motion_request;
		logic        clear_error;
		logic        errors_present;
	} dse_item_t;

	typedef struct packed {
		seq_state_t  seq;
		logic        target;
		logic [15:0] wdog;
		logic [15:0] cw;
		logic        err;
	} dse_state_t;

	typedef struct packed {
		logic [15:0] control_word;
		logic [2:0]  sequence_state;
		logic        error_code;
		logic        enable_accepted;
		logic        motion_enabled;
	} dse_result_t;

endpackage

### src/dse_step.sv
// Drive enable sequencer step: one fieldbus cycle of next-state logic
// (error clear, request, watchdog, sequencer) as combinational logic.
// Depends on dse_pkg.
module dse_step (
	input  logic [1:0]          mode_class,
	input  dse_pkg::dse_item_t  item,
	input  dse_pkg::dse_state_t cur,
	output dse_pkg::dse_state_t nxt,
	output dse_pkg::dse_result_t res
);
	import dse_pkg::*;

	logic        err_clr;
	logic        accepted;
	logic        tgt_req;
	logic [15:0] cnt_inc;
	logic        trip;
	dse_state_t  pre;
	logic [15:0] sw_a;
	logic [15:0] sw_b;
	logic        stop_req;
	seq_state_t  seq_next;
	logic [15:0] cw_next;
	logic        wdog_clr;

	function automatic logic [15:0] with_ip(input logic [1:0] mode, input logic [15:0] cw);
		with_ip = (mode == MODE_POSITION) ? (cw | CW_IP_ENABLE) : cw;
	endfunction

	// error clear, request handling and watchdog ahead of the sequencer
	always_comb begin
		err_clr  = cur.err & ~item.clear_error;
		accepted = (item.motion_request == REQ_ENABLE) && !err_clr &&
			!item.errors_present && (cur.seq == ST_STOP);
		if (accepted) begin
			tgt_req = 1'b1;
		end else if (item.motion_request == REQ_DISABLE) begin
			tgt_req = 1'b0;
		end else begin
			tgt_req = cur.target;
		end
		cnt_inc = (cur.wdog == WDOG_MAX) ? cur.wdog : cur.wdog + 16'd1;
		trip    = (cnt_inc >= WATCHDOG_TICKS);

		pre.err    = err_clr | trip;
		pre.seq    = trip ? ST_STOP : cur.seq;
		pre.target = trip ? 1'b0 : tgt_req;
		pre.wdog   = trip ? 16'd0 : cnt_inc;
		pre.cw     = trip ? CW_NONE : cur.cw;
	end

	assign sw_a     = item.drive_status & MASK_STATE_A;
	assign sw_b     = item.drive_status & MASK_STATE_B;
	assign stop_req = !pre.target;

	// sequencer next state
	always_comb begin
		seq_next = pre.seq;
		case (pre.seq)
			ST_ENABLE: begin
				if (stop_req) begin
					seq_next = ST_STOP;
				end else if (sw_a == SW_SWITCH_ON_DISABLED || sw_b == SW_READY) begin
					seq_next = ST_CTRL1;
				end
			end
			ST_CTRL1: begin
				if (stop_req) begin
					seq_next = ST_DISENGAGING;
				end else if (sw_b == SW_READY) begin
					seq_next = ST_CTRL2;
				end
			end
			ST_CTRL2: begin
				if (stop_req) begin
					seq_next = ST_DISENGAGING;
				end else if (sw_b == SW_SWITCHED_ON) begin
					seq_next = ST_ENGAGING;
				end
			end
			ST_ENGAGING: begin
				if (stop_req) begin
					seq_next = ST_DISENGAGING;
				end else if (sw_b == SW_OP_ENABLED) begin
					seq_next = ST_MOTION;
				end
			end
			ST_MOTION: begin
				if (stop_req) begin
					seq_next = ST_DISENGAGING;
				end
			end
			ST_DISENGAGING: seq_next = ST_STOPPING;
			ST_STOPPING: begin
				if (sw_b != SW_QUICK_STOP_ACTIVE) begin
					seq_next = ST_DISABLE;
				end
			end
			ST_DISABLE: seq_next = ST_STOP;
			default: begin
				// stop: hold while faulted, in fault reaction or with no motion target
				seq_next = ST_STOP;
				if (sw_a != SW_FAULT && sw_a != SW_FAULT_REACTION && !stop_req) begin
					seq_next = ST_ENABLE;
				end
			end
		endcase
	end

	// sequencer outputs: held controlword and watchdog clear
	always_comb begin
		cw_next  = pre.cw;
		wdog_clr = 1'b0;
		case (pre.seq)
			ST_ENABLE: begin
				if (stop_req) begin
					wdog_clr = 1'b1;
				end else if (sw_a == SW_SWITCH_ON_DISABLED) begin
					cw_next  = with_ip(mode_class, CW_SHUTDOWN);
					wdog_clr = 1'b1;
				end else if (sw_b == SW_READY) begin
					wdog_clr = 1'b1;
				end
			end
			ST_CTRL1: begin
				if (stop_req) begin
					wdog_clr = 1'b1;
				end else if (sw_b == SW_READY) begin
					cw_next  = with_ip(mode_class, CW_SWITCH_ON);
					wdog_clr = 1'b1;
				end
			end
			ST_CTRL2: begin
				// entering engaging keeps the count running
				if (stop_req) begin
					wdog_clr = 1'b1;
				end else if (sw_b == SW_SWITCHED_ON) begin
					cw_next = with_ip(mode_class, CW_ENABLE_OP);
				end
			end
			ST_ENGAGING: begin
				wdog_clr = stop_req || (sw_b == SW_OP_ENABLED);
			end
			ST_MOTION: wdog_clr = 1'b1;
			ST_DISENGAGING: begin
				cw_next  = CW_QUICK_STOP;
				wdog_clr = 1'b1;
			end
			ST_STOPPING: wdog_clr = (sw_b == SW_QUICK_STOP_ACTIVE);
			ST_DISABLE: wdog_clr = 1'b1;
			default: begin
				cw_next  = (sw_a == SW_FAULT) ? CW_FAULT_RESET : CW_NONE;
				wdog_clr = 1'b1;
			end
		endcase
	end

	always_comb begin
		nxt.err    = pre.err;
		nxt.target = pre.target;
		if (item.motor_on) begin
			nxt.seq  = seq_next;
			nxt.cw   = cw_next;
			nxt.wdog = wdog_clr ? 16'd0 : pre.wdog;
		end else begin
			nxt.seq  = ST_STOP;
			nxt.cw   = CW_NONE;
			nxt.wdog = 16'd0;
		end

		res.control_word    = nxt.cw;
		res.sequence_state  = (nxt.seq == ST_DISABLE) ? SHOWN_STOPPING : nxt.seq[2:0];
		res.error_code      = nxt.err;
		res.enable_accepted = accepted;
		res.motion_enabled  = nxt.target || (nxt.seq != ST_STOP);
	end

endmodule

### src/drive_enable_sequencer.sv
// Drive enable sequencer top level: input register, sequencer state, result
// register and handshake control. Depends on dse_pkg and dse_step.
//
// Usage: one input beat is one fieldbus cycle (motor enable, statusword,
// motion request, error clear, external error flag). Each input beat yields
// exactly one result beat: the controlword to send, the reported sequence
// state, the latched watchdog error, whether this cycle's enable request was
// taken, and whether motion is enabled.
// Both channels use valid/ready. An input beat is captured in the input
// register; when the result register is free or being read, the step logic
// updates the sequencer state and loads the result register, and result
// valid rises. One beat per clock is sustained unless the receiver stalls,
// set by the single pass through the step logic. When the receiver stalls,
// the result register holds and one more beat waits in the input register;
// ready drops only when both are full. mode_class must be written through
// cfg_wr_en/cfg_wr_data only while the block is idle; this is not enforced.
// Reset (arst_n low) clears state to STOP, the controlword, watchdog,
// error latch and mode_class, and empties both registers.
module drive_enable_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        motor_on,
	input  logic [15:0] drive_status,
	input  logic [1:0]  motion_request,
	input  logic        clear_error,
	input  logic        errors_present,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] control_word,
	output logic [2:0]  sequence_state,
	output logic        error_code,
	output logic        enable_accepted,
	output logic        motion_enabled
);
	import dse_pkg::*;

	logic [1:0]  mode_class_q;
	dse_item_t   item_s1;
	logic        valid_s1;
	dse_state_t  state_q;
	dse_state_t  state_nxt;
	dse_result_t res_nxt;
	dse_result_t res_q;
	logic        valid_out_q;
	logic        advance;

	assign advance  = valid_s1 && (!valid_out_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_class_q <= 2'd0;
		end else if (cfg_wr_en) begin
			mode_class_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.motor_on       <= motor_on;
			item_s1.drive_status   <= drive_status;
			item_s1.motion_request <= motion_request;
			item_s1.clear_error    <= clear_error;
			item_s1.errors_present <= errors_present;
		end
	end

	dse_step u_step (
		.mode_class (mode_class_q),
		.item       (item_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.seq    <= ST_STOP;
			state_q.target <= 1'b0;
			state_q.wdog   <= 16'd0;
			state_q.cw     <= CW_NONE;
			state_q.err    <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q <= 1'b0;
		end else if (advance) begin
			valid_out_q <= 1'b1;
		end else if (out_ready) begin
			valid_out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = valid_out_q;
	assign control_word    = res_q.control_word;
	assign sequence_state  = res_q.sequence_state;
	assign error_code      = res_q.error_code;
	assign enable_accepted = res_q.enable_accepted;
	assign motion_enabled  = res_q.motion_enabled;

`ifndef SYNTHESIS
	// a trip clears the count, so the stored count never reaches the limit
	a_wdog_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.wdog < WATCHDOG_TICKS)
		else $error("watchdog count reached limit in stored state");

	// an accepted enable always leaves motion enabled
	a_accept_enables: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable_accepted |-> motion_enabled)
		else $error("accepted enable without motion enabled");

	// both stages full and stalled: no new beat may enter
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_out_q && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline full");

	// state only moves when a beat passes to the result register
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a beat");
`endif

endmodule

### verif/drive_enable_sequencer_tb.sv
// Testbench for drive_enable_sequencer: steps its own copy of the sequencer
// per accepted beat and checks every result beat in order.
// Depends on dse_pkg and the drive_enable_sequencer RTL.
`timescale 1ns / 100ps

module drive_enable_sequencer_tb;
	import dse_pkg::*;

	localparam logic [1:0] REQ_NONE    = 2'd0;
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam logic [1:0] MODE_NONE     = 2'd0;
	localparam logic [1:0] MODE_VELOCITY = 2'd2;
	localparam logic [1:0] MODE_TORQUE   = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        motor_on;
	logic [15:0] drive_status;
	logic [1:0]  motion_request;
	logic        clear_error;
	logic        errors_present;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] control_word;
	logic [2:0]  sequence_state;
	logic        error_code;
	logic        enable_accepted;
	logic        motion_enabled;

	drive_enable_sequencer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.motor_on       (motor_on),
		.drive_status   (drive_status),
		.motion_request (motion_request),
		.clear_error    (clear_error),
		.errors_present (errors_present),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.control_word   (control_word),
		.sequence_state (sequence_state),
		.error_code     (error_code),
		.enable_accepted(enable_accepted),
		.motion_enabled (motion_enabled)
	);

	// predicted sequencer state
	seq_state_t  seq_now;
	logic        target_motion;
	logic [15:0] wdog_ticks;
	logic [15:0] cw_held;
	logic        err_latched;
	logic [1:0]  mode_q;

	dse_result_t pending_results[$];
	dse_result_t want;
	int unsigned fail_count;

	// flow control knobs
	bit quiet;
	bit no_gaps;
	bit hold_long;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [15:0] add_ip(logic [15:0] cw);
		return (mode_q == MODE_POSITION) ? (cw | CW_IP_ENABLE) : cw;
	endfunction

	function automatic void sequence_step(logic [15:0] sw);
		logic [15:0] sa;
		logic [15:0] sb;
		logic        halt;
		sa = sw & MASK_STATE_A;
		sb = sw & MASK_STATE_B;
		halt = !target_motion;
		case (seq_now)
			ST_ENABLE: begin
				if (halt) begin
					seq_now = ST_STOP;
					wdog_ticks = '0;
				end else if (sa == SW_SWITCH_ON_DISABLED) begin
					cw_held = add_ip(CW_SHUTDOWN);
					seq_now = ST_CTRL1;
					wdog_ticks = '0;
				end else if (sb == SW_READY) begin
					seq_now = ST_CTRL1;
					wdog_ticks = '0;
				end
			end
			ST_CTRL1: begin
				if (halt) begin
					seq_now = ST_DISENGAGING;
					wdog_ticks = '0;
				end else if (sb == SW_READY) begin
					cw_held = add_ip(CW_SWITCH_ON);
					seq_now = ST_CTRL2;
					wdog_ticks = '0;
				end
			end
			ST_CTRL2: begin
				if (halt) begin
					seq_now = ST_DISENGAGING;
					wdog_ticks = '0;
				end else if (sb == SW_SWITCHED_ON) begin
					// watchdog keeps running into ENGAGING
					cw_held = add_ip(CW_ENABLE_OP);
					seq_now = ST_ENGAGING;
				end
			end
			ST_ENGAGING: begin
				if (halt) begin
					seq_now = ST_DISENGAGING;
					wdog_ticks = '0;
				end else if (sb == SW_OP_ENABLED) begin
					seq_now = ST_MOTION;
					wdog_ticks = '0;
				end
			end
			ST_MOTION: begin
				if (halt)
					seq_now = ST_DISENGAGING;
				wdog_ticks = '0;
			end
			ST_DISENGAGING: begin
				cw_held = CW_QUICK_STOP;
				seq_now = ST_STOPPING;
				wdog_ticks = '0;
			end
			ST_STOPPING: begin
				if (sb == SW_QUICK_STOP_ACTIVE)
					wdog_ticks = '0;
				else
					seq_now = ST_DISABLE;
			end
			ST_DISABLE: begin
				seq_now = ST_STOP;
				wdog_ticks = '0;
			end
			default: begin
				seq_now = ST_STOP;
				cw_held = CW_NONE;
				if (sa == SW_FAULT)
					cw_held = CW_FAULT_RESET;
				else if (sa != SW_FAULT_REACTION && !halt)
					seq_now = ST_ENABLE;
				wdog_ticks = '0;
			end
		endcase
	endfunction

	function automatic dse_result_t advance_sequencer(dse_item_t it);
		dse_result_t r;
		logic        took;
		logic [3:0]  st_bits;
		took = 1'b0;
		if (it.clear_error)
			err_latched = 1'b0;
		if (it.motion_request == REQ_ENABLE) begin
			if (!err_latched && !it.errors_present && seq_now == ST_STOP) begin
				target_motion = 1'b1;
				took = 1'b1;
			end
		end else if (it.motion_request == REQ_DISABLE) begin
			target_motion = 1'b0;
		end
		if (wdog_ticks != WDOG_MAX)
			wdog_ticks = wdog_ticks + 16'd1;
		if (wdog_ticks >= WATCHDOG_TICKS) begin
			err_latched = 1'b1;
			seq_now = ST_STOP;
			target_motion = 1'b0;
			wdog_ticks = '0;
			cw_held = CW_NONE;
		end
		if (it.motor_on) begin
			sequence_step(it.drive_status);
		end else begin
			cw_held = CW_NONE;
			seq_now = ST_STOP;
			wdog_ticks = '0;
		end
		st_bits = seq_now;
		r.control_word = cw_held;
		r.sequence_state = (seq_now == ST_DISABLE) ? SHOWN_STOPPING : st_bits[2:0];
		r.error_code = err_latched;
		r.enable_accepted = took;
		r.motion_enabled = target_motion || (seq_now != ST_STOP);
		return r;
	endfunction

	function automatic dse_item_t make_item(logic me, logic [15:0] sw, logic [1:0] req,
			logic clr, logic errs);
		dse_item_t it;
		it.motor_on = me;
		it.drive_status = sw;
		it.motion_request = req;
		it.clear_error = clr;
		it.errors_present = errs;
		return it;
	endfunction

	// random statusword whose masked bits equal the pattern
	function automatic logic [15:0] fit_status(logic [15:0] pattern, logic [15:0] mask);
		logic [15:0] noise;
		noise = 16'($urandom_range(0, 65535));
		return (noise & ~mask) | pattern;
	endfunction

	// statusword of a drive that mostly follows the commanded transitions
	function automatic logic [15:0] drive_reply();
		logic [15:0] sw;
		sw = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 4) == 0)
			return sw;
		case (seq_now)
			ST_STOP: begin
				case ($urandom_range(0, 9))
					0: sw = fit_status(SW_FAULT, MASK_STATE_A);
					1: sw = fit_status(SW_FAULT_REACTION, MASK_STATE_A);
					default: sw = fit_status(SW_SWITCH_ON_DISABLED, MASK_STATE_A);
				endcase
			end
			ST_ENABLE: begin
				if ($urandom_range(0, 1))
					sw = fit_status(SW_SWITCH_ON_DISABLED, MASK_STATE_A);
				else
					sw = fit_status(SW_READY, MASK_STATE_B);
			end
			ST_CTRL1: sw = fit_status(SW_READY, MASK_STATE_B);
			ST_CTRL2: sw = fit_status(SW_SWITCHED_ON, MASK_STATE_B);
			ST_ENGAGING: sw = fit_status(SW_OP_ENABLED, MASK_STATE_B);
			ST_MOTION: sw = fit_status(SW_OP_ENABLED, MASK_STATE_B);
			ST_STOPPING: begin
				if ($urandom_range(0, 2) != 0)
					sw = fit_status(SW_QUICK_STOP_ACTIVE, MASK_STATE_B);
			end
			default: ;
		endcase
		return sw;
	endfunction

	function automatic dse_item_t random_cycle();
		dse_item_t it;
		it.motor_on = ($urandom_range(0, 39) != 0);
		it.drive_status = drive_reply();
		it.clear_error = err_latched ? ($urandom_range(0, 3) == 0)
			: ($urandom_range(0, 19) == 0);
		it.errors_present = ($urandom_range(0, 9) == 0);
		if (seq_now == ST_STOP && !target_motion && $urandom_range(0, 9) < 6)
			it.motion_request = REQ_ENABLE;
		else if (seq_now == ST_MOTION && $urandom_range(0, 9) == 0)
			it.motion_request = REQ_DISABLE;
		else if ($urandom_range(0, 9) == 0)
			it.motion_request = 2'($urandom_range(0, 3));
		else
			it.motion_request = REQ_NONE;
		return it;
	endfunction

	// statusword that lets the sequencer sit in ENABLE
	function automatic logic [15:0] stalled_status();
		logic [15:0] sw;
		logic [15:0] sb;
		do begin
			sw = 16'($urandom_range(0, 65535));
			sb = sw & MASK_STATE_B;
		end while ((sw & MASK_STATE_A) == SW_SWITCH_ON_DISABLED || sb == SW_READY
			|| sb == SW_SWITCHED_ON || sb == SW_OP_ENABLED);
		return sw;
	endfunction

	task automatic send_cycle(dse_item_t it);
		int unsigned gap;
		@(negedge clk);
		if (!quiet && !no_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		motor_on <= it.motor_on;
		drive_status <= it.drive_status;
		motion_request <= it.motion_request;
		clear_error <= it.clear_error;
		errors_present <= it.errors_present;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		pending_results.push_back(advance_sequencer(it));
	endtask

	task automatic drain_results();
		int unsigned waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			fail_count++;
			$display("%0d result beats never arrived", pending_results.size());
			pending_results.delete();
		end
	endtask

	task automatic write_mode_class(logic [1:0] m);
		@(negedge clk);
		cfg_wr_data <= m;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mode_q = m;
	endtask

	task automatic test_directed();
		write_mode_class(MODE_POSITION);
		send_cycle(make_item(1'b0, 16'hffff, REQ_IGNORED, 1'b1, 1'b1));
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b0, 1'b1));
		send_cycle(make_item(1'b1, 16'hff88, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'hff8f, REQ_ENABLE, 1'b1, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b0, 1'b0));
		// full power-up walk with the interpolation bit
		send_cycle(make_item(1'b1, SW_SWITCH_ON_DISABLED, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_IGNORED, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, SW_READY, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, SW_SWITCHED_ON, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, SW_OP_ENABLED, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'hffff, REQ_NONE, 1'b1, 1'b1));
		send_cycle(make_item(1'b1, 16'h0000, REQ_DISABLE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, SW_QUICK_STOP_ACTIVE, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_NONE, 1'b0, 1'b0));
		// ready path out of ENABLE, then motor drop, then stop in ENABLE
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, SW_READY, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b0, SW_READY, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_NONE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_DISABLE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h8000, REQ_ENABLE, 1'b0, 1'b0));
	endtask

	task automatic test_watchdog();
		int unsigned n;
		logic [1:0]  req;
		send_cycle(make_item(1'b0, 16'h0000, REQ_DISABLE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b1, 1'b0));
		n = 0;
		while (!err_latched && n < 1100) begin
			req = $urandom_range(0, 1) ? REQ_IGNORED : REQ_NONE;
			send_cycle(make_item(1'b1, stalled_status(), req,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			n++;
		end
		// latched error refuses enable until cleared in the same beat
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b0, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_ENABLE, 1'b1, 1'b0));
		send_cycle(make_item(1'b1, 16'h0000, REQ_DISABLE, 1'b0, 1'b0));
	endtask

	task automatic test_random_phase(logic [1:0] m, int unsigned n);
		drain_results();
		write_mode_class(m);
		repeat (n) send_cycle(random_cycle());
	endtask

	task automatic test_backpressure();
		hold_long = 1'b1;
		no_gaps = 1'b1;
		repeat (30) send_cycle(random_cycle());
		no_gaps = 1'b0;
	endtask

	task automatic test_quiet_tail();
		quiet = 1'b1;
		repeat (16) send_cycle(random_cycle());
	endtask

	// result receiver
	initial begin
		int unsigned n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (50) @(negedge clk);
				hold_long = 1'b0;
				out_ready <= 1'b1;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result beat with nothing pending: cw=%h state=%0d",
						control_word, sequence_state);
			end else begin
				want = pending_results.pop_front();
				if (want.control_word !== control_word
						|| want.sequence_state !== sequence_state
						|| want.error_code !== error_code
						|| want.enable_accepted !== enable_accepted
						|| want.motion_enabled !== motion_enabled) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: cw %h/%h state %0d/%0d err %b/%b acc %b/%b en %b/%b",
							want.control_word, control_word,
							want.sequence_state, sequence_state,
							want.error_code, error_code,
							want.enable_accepted, enable_accepted,
							want.motion_enabled, motion_enabled);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = MODE_NONE;
		in_valid = 1'b0;
		motor_on = 1'b0;
		drive_status = 16'h0000;
		motion_request = REQ_NONE;
		clear_error = 1'b0;
		errors_present = 1'b0;
		quiet = 1'b0;
		no_gaps = 1'b0;
		hold_long = 1'b0;
		fail_count = 0;
		seq_now = ST_STOP;
		target_motion = 1'b0;
		wdog_ticks = '0;
		cw_held = CW_NONE;
		err_latched = 1'b0;
		mode_q = MODE_NONE;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_watchdog();
		test_random_phase(MODE_NONE, 6);
		test_random_phase(MODE_TORQUE, 6);
		test_backpressure();
		test_random_phase(MODE_VELOCITY, 6);
		test_random_phase(MODE_POSITION, 6);
		test_random_phase(MODE_NONE, 0);
		test_quiet_tail();

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
src/dse_pkg.sv
src/dse_step.sv
src/drive_enable_sequencer.sv
verif/drive_enable_sequencer_tb.sv
